### rtl/assert_macros.svh
// Assertion helpers included by the bitcrusher RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bsh_pkg.sv
package bsh_pkg;

   // Default sample width
   localparam int SAMPLE_BITS_DEF = 16;

   // Noise generator seed
   localparam logic [31:0] RNG_SEED = 32'h9E3779B9;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_QUANT_BITS      = 3'd0,
      CSR_DOWNSAMPLE_BASE = 3'd1,
      CSR_JITTER_SPAN     = 3'd2,
      CSR_NOISE_SCALE     = 3'd3,
      CSR_WRAP_GAIN       = 3'd4,
      CSR_MIX_LEVEL       = 3'd5
   } csr_index_type;

   // Register reset values
   localparam logic [3:0]  QUANT_RST  = 4'd15;
   localparam logic [6:0]  BASE_RST   = 7'd1;
   localparam logic [5:0]  JSPAN_RST  = 6'd0;
   localparam logic [9:0]  NSCALE_RST = 10'd0;
   localparam logic [15:0] WGAIN_RST  = 16'd8192;
   localparam logic [15:0] MIX_RST    = 16'd32768;

   // Longest hold the 7-bit counter supports
   localparam logic [7:0] MAX_HOLD = 8'd128;

   // Serial multiplier step counts, minus one
   localparam logic [3:0] JIT_STEPS_M1   = 4'd6;
   localparam logic [3:0] NOISE_STEPS_M1 = 4'd9;
   localparam logic [3:0] WRAP_STEPS_M1  = 4'd15;
   localparam logic [3:0] MIX_STEPS_M1   = 4'd15;

   // One xorshift32 advance (shifts 13, 17, 5)
   function automatic logic [31:0] xorshift32(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      c = b ^ (b << 5);
      return c;
   endfunction

endpackage

### rtl/bitcrusher_sample_hold_wrap.sv
// Sample-and-hold bitcrusher with jittered hold length, noise and wrap drive.
// Request channel (req_*): one signed sample per request, taken while the
// block is idle. Response channel (rsp_*): one signed sample per request,
// held in an output register until the receiver takes it.
// Configuration (csr_*): write-only registers, to be written only while the
// block idles; the user is bound to this, the block does not enforce it.
// Every request runs through one shared shift-add multiplier that consumes
// one multiplier bit per cycle: jitter draw, then on a reload optional noise
// scaling and wrap gain, then output level; a kept held sample skips the
// noise and wrap gain. The next request is taken the cycle after the
// response is registered.
// A stalled receiver holds the response; a finished result waits in the
// final state until the output register frees, while one earlier response
// can still be pending. Reset clears the hold counter and held sample,
// reseeds the generator and loads the register defaults; there is no
// clearing pass.
`include "assert_macros.svh"

module bitcrusher_sample_hold_wrap #(
   parameter int SAMPLE_BITS = bsh_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // sample_in
   // response
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,  // sample_out
   // configuration
   input  logic                                   csr_we,
   input  logic [bsh_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [bsh_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int FRAC_BITS = SAMPLE_BITS - 1;
   localparam int DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SUM_W     = ((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) + 1;
   localparam int ACC_W     = SUM_W + 16;
   localparam int SH_W      = $clog2(FRAC_BITS + 1);
   localparam int CMP_W     = (SH_W > 4) ? SH_W : 4;
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_JIT,
      ST_DECIDE,
      ST_NOISE,
      ST_QUANT,
      ST_WRAP,
      ST_HELD,
      ST_MIX,
      ST_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [SAMPLE_BITS-1:0]   smp_ff, smp_in;
   logic [31:0]              rng_ff, rng_in;
   logic [6:0]               hold_ff, hold_in;
   logic [SAMPLE_BITS-1:0]   held_ff, held_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [15:0]              mplier_ff, mplier_in;
   logic [3:0]               step_ff, step_in;
   logic [3:0]               quant_ff, quant_in;
   logic [6:0]               base_ff, base_in;
   logic [5:0]               jspan_ff, jspan_in;
   logic [9:0]               nscale_ff, nscale_in;
   logic [15:0]              wgain_ff, wgain_in;
   logic [15:0]              mix_ff, mix_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic [31:0]              rng_step;
   logic                     mul_last;
   logic signed [ACC_W-1:0]  acc_add;
   logic [6:0]               jitter;
   logic [7:0]               len_raw;
   logic [7:0]               len_clip;
   logic [7:0]               hold_next;
   logic                     reload;
   logic signed [10:0]       noise;
   logic signed [SUM_W-1:0]  sum_raw;
   logic [SH_W-1:0]          sh;
   logic [SUM_W-1:0]         qmask;
   logic signed [SUM_W-1:0]  sum_q;
   logic [SAMPLE_BITS-1:0]   held_new;
   logic signed [ACC_W-1:0]  o_full;
   logic [SAMPLE_BITS-1:0]   o_sat;

   // Shared datapath pieces
   assign rng_step  = bsh_pkg::xorshift32(rng_ff);
   assign mul_last  = (step_ff == 4'd0);
   assign acc_add   = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign jitter    = acc_ff[22:16];
   assign len_raw   = {1'b0, base_ff} + {1'b0, jitter};
   assign hold_next = {1'b0, hold_ff} + 8'd1;
   assign noise     = acc_ff[25:15];
   assign sum_raw   = SUM_W'($signed(smp_ff)) + SUM_W'(noise);
   assign held_new  = acc_ff[13 +: SAMPLE_BITS];
   assign o_full    = acc_ff >>> FRAC_BITS;

   // Clamp hold length to 1..128
   always_comb begin
      priority if (len_raw == 8'd0) begin
         len_clip = 8'd1;
      end else if (len_raw > bsh_pkg::MAX_HOLD) begin
         len_clip = bsh_pkg::MAX_HOLD;
      end else begin
         len_clip = len_raw;
      end
   end

   assign reload = (hold_next >= len_clip);

   // Floor to quant_bits fractional bits
   always_comb begin
      if (CMP_W'(quant_ff) < CMP_W'(FRAC_BITS)) begin
         sh = SH_W'(CMP_W'(FRAC_BITS) - CMP_W'(quant_ff));
      end else begin
         sh = '0;
      end
      for (int i = 0; i < SUM_W; i++) begin
         qmask[i] = (i >= int'(sh));
      end
   end

   assign sum_q = sum_raw & $signed(qmask);

   // Saturate output level product
   always_comb begin
      priority if (o_full > OUT_MAX) begin
         o_sat = OUT_MAX[SAMPLE_BITS-1:0];
      end else if (o_full < OUT_MIN) begin
         o_sat = OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
         o_sat = o_full[SAMPLE_BITS-1:0];
      end
   end

   // Sequencer and register next values
   always_comb begin
      state_in     = state_ff;
      smp_in       = smp_ff;
      rng_in       = rng_ff;
      hold_in      = hold_ff;
      held_in      = held_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      step_in      = step_ff;
      quant_in     = quant_ff;
      base_in      = base_ff;
      jspan_in     = jspan_ff;
      nscale_in    = nscale_ff;
      wgain_in     = wgain_ff;
      mix_in       = mix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Write configuration
      if (csr_we) begin
         unique case (bsh_pkg::csr_index_type'(csr_addr))
            bsh_pkg::CSR_QUANT_BITS:      quant_in  = csr_wdata[3:0];
            bsh_pkg::CSR_DOWNSAMPLE_BASE: base_in   = csr_wdata[6:0];
            bsh_pkg::CSR_JITTER_SPAN:     jspan_in  = csr_wdata[5:0];
            bsh_pkg::CSR_NOISE_SCALE:     nscale_in = csr_wdata[9:0];
            bsh_pkg::CSR_WRAP_GAIN:       wgain_in  = csr_wdata[15:0];
            bsh_pkg::CSR_MIX_LEVEL:       mix_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      // Drop response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               smp_in    = req_tdata[SAMPLE_BITS-1:0];
               rng_in    = rng_step;
               acc_in    = '0;
               mcand_in  = ACC_W'(rng_step[31:16]);
               mplier_in = 16'({1'b0, jspan_ff} + 7'd1);
               step_in   = bsh_pkg::JIT_STEPS_M1;
               state_in  = ST_JIT;
            end
         end
         ST_JIT, ST_NOISE, ST_WRAP, ST_MIX: begin
            // Advance the serial multiplier one bit
            acc_in    = acc_add;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 4'd1;
            if (mul_last) begin
               unique case (state_ff)
                  ST_JIT:   state_in = ST_DECIDE;
                  ST_NOISE: state_in = ST_QUANT;
                  ST_WRAP:  state_in = ST_HELD;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_DECIDE: begin
            acc_in = '0;
            if (reload) begin
               hold_in = '0;
               if (nscale_ff != 10'd0) begin
                  rng_in    = rng_step;
                  mcand_in  = ACC_W'($signed({~rng_step[31], rng_step[30:16]}));
                  mplier_in = 16'(nscale_ff);
                  step_in   = bsh_pkg::NOISE_STEPS_M1;
                  state_in  = ST_NOISE;
               end else begin
                  state_in = ST_QUANT;
               end
            end else begin
               hold_in   = hold_next[6:0];
               mcand_in  = ACC_W'($signed(held_ff));
               mplier_in = mix_ff;
               step_in   = bsh_pkg::MIX_STEPS_M1;
               state_in  = ST_MIX;
            end
         end
         ST_QUANT: begin
            acc_in    = '0;
            mcand_in  = ACC_W'(sum_q);
            mplier_in = wgain_ff;
            step_in   = bsh_pkg::WRAP_STEPS_M1;
            state_in  = ST_WRAP;
         end
         ST_HELD: begin
            held_in   = held_new;
            acc_in    = '0;
            mcand_in  = ACC_W'($signed(held_new));
            mplier_in = mix_ff;
            step_in   = bsh_pkg::MIX_STEPS_M1;
            state_in  = ST_MIX;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = o_sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= bsh_pkg::RNG_SEED;
         hold_ff      <= '0;
         held_ff      <= '0;
         quant_ff     <= bsh_pkg::QUANT_RST;
         base_ff      <= bsh_pkg::BASE_RST;
         jspan_ff     <= bsh_pkg::JSPAN_RST;
         nscale_ff    <= bsh_pkg::NSCALE_RST;
         wgain_ff     <= bsh_pkg::WGAIN_RST;
         mix_ff       <= bsh_pkg::MIX_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         hold_ff      <= hold_in;
         held_ff      <= held_in;
         quant_ff     <= quant_in;
         base_ff      <= base_in;
         jspan_ff     <= jspan_in;
         nscale_ff    <= nscale_in;
         wgain_ff     <= wgain_in;
         mix_ff       <= mix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

   // Checks
   `ASSERT_SAME(a_rng_nonzero, clock, reset, 1'b1, rng_ff != 32'd0,
      "noise generator reached the all-zero state")
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready,
      state_ff == ST_JIT, "accepted request did not start the jitter draw")
   `ASSERT_NEXT(a_reload_clears, clock, reset, state_ff == ST_DECIDE && reload,
      hold_ff == 7'd0, "hold counter not cleared on reload")
   `ASSERT_SAME(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_OUT), "response raised outside the output state")

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import bsh_pkg::*;

   // Longest quiet stretch before the block counts as hung; it must cover one
   // sample, the long receiver hold-off and the random gaps.
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_STALL  = 400;
   localparam int TAIL_CYCLES = 60;

   // Register indexes the block does not decode
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [15:0] EDGE_SAMPLES  [7] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                                 16'h0001, 16'h5555, 16'hAAAA};
   localparam logic [15:0] CRUSH_SAMPLES [6] = '{16'h8000, 16'h7FFF, 16'h1234, 16'hC000,
                                                 16'h0000, 16'h4000};

   // Predicts the crushed output of each request and checks responses in order
   class crush_scoreboard;
      logic [3:0]  frac_keep;
      logic [6:0]  hold_base;
      logic [5:0]  hold_spread;
      logic [9:0]  noise_amp;
      logic [15:0] drive_gain;
      logic [15:0] out_level;
      logic [6:0]  hold_ctr;
      logic [15:0] held_value;
      logic [31:0] noise_gen;
      logic [15:0] expected_samples[$];
      int          mismatches;

      function new();
         frac_keep   = QUANT_RST;
         hold_base   = BASE_RST;
         hold_spread = JSPAN_RST;
         noise_amp   = NSCALE_RST;
         drive_gain  = WGAIN_RST;
         out_level   = MIX_RST;
         hold_ctr    = '0;
         held_value  = '0;
         noise_gen   = RNG_SEED;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_QUANT_BITS:      frac_keep   = v[3:0];
            CSR_DOWNSAMPLE_BASE: hold_base   = v[6:0];
            CSR_JITTER_SPAN:     hold_spread = v[5:0];
            CSR_NOISE_SCALE:     noise_amp   = v[9:0];
            CSR_WRAP_GAIN:       drive_gain  = v;
            CSR_MIX_LEVEL:       out_level   = v;
            default: ;
         endcase
      endfunction

      // Advance the xorshift generator (shifts 13, 17, 5)
      function logic [31:0] advance_gen();
         logic [31:0] x;
         x = noise_gen;
         x = x ^ (x << 13);
         x = x ^ (x >> 17);
         x = x ^ (x << 5);
         noise_gen = x;
         return x;
      endfunction

      function void note_request(logic [15:0] din);
         logic [31:0] draw;
         int unsigned spread;
         int unsigned span;
         int unsigned next_ctr;
         longint      acc;
         longint      noise;
         longint      scaled;
         longint      level;
         int          shift;
         draw   = advance_gen();
         spread = (32'(draw[31:16]) * (32'(hold_spread) + 32'd1)) >> 16;
         span   = 32'(hold_base) + spread;
         if (span < 1)
            span = 1;
         if (span > 32'(MAX_HOLD))
            span = 32'(MAX_HOLD);
         next_ctr = 32'(hold_ctr) + 32'd1;

         // Reload the held sample at the end of the hold
         if (next_ctr >= span) begin
            hold_ctr = '0;
            acc = longint'($signed(din));
            if (noise_amp != 0) begin
               draw  = advance_gen();
               noise = longint'(draw[31:16]) - 64'sd32768;
               acc   = acc + ((noise * longint'(noise_amp)) >>> 15);
            end
            shift      = (frac_keep < 4'd15) ? 15 - int'(frac_keep) : 0;
            acc        = acc & ~((64'sd1 <<< shift) - 64'sd1);
            scaled     = (acc * longint'(drive_gain)) >>> 13;
            held_value = scaled[15:0];
         end else begin
            hold_ctr = next_ctr[6:0];
         end

         // Scale by the output level and saturate
         level = (longint'($signed(held_value)) * longint'(out_level)) >>> 15;
         if (level > 32767)
            level = 32767;
         if (level < -32768)
            level = -32768;
         expected_samples.push_back(level[15:0]);
      endfunction

      function void check_response(logic [15:0] got);
         logic [15:0] want;
         if (expected_samples.size() == 0) begin
            $error("sample_out: expected no response, actual %0d", $signed(got));
            mismatches++;
         end else begin
            want = expected_samples.pop_front();
            if (want !== got) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      $signed(want), $signed(got));
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   crush_scoreboard sb;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   bit long_stall_req  = 1'b0;
   bit long_stall_done = 1'b0;
   int long_stall_left = 0;
   int quiet_cycles    = 0;

   bitcrusher_sample_hold_wrap u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive the receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_stall_req && !long_stall_done) begin
         long_stall_left = LONG_STALL;
         long_stall_done = 1'b1;
      end
      if (long_stall_left > 0) begin
         long_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Note requests, check responses, and watch for a hung block
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Offer one request after random idle cycles; return at the falling edge
   task automatic send_sample(input logic [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input logic [15:0] q, input logic [15:0] b,
                              input logic [15:0] j, input logic [15:0] n,
                              input logic [15:0] g, input logic [15:0] m);
      write_reg(CSR_QUANT_BITS, q);
      write_reg(CSR_DOWNSAMPLE_BASE, b);
      write_reg(CSR_JITTER_SPAN, j);
      write_reg(CSR_NOISE_SCALE, n);
      write_reg(CSR_WRAP_GAIN, g);
      write_reg(CSR_MIX_LEVEL, m);
   endtask

   // Drop valid and wait until every response is back
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   // Pick a register setting: fixed extremes first, then random ones
   task automatic pick_config(input int kind);
      logic [15:0] b;
      logic [15:0] j;
      logic [15:0] n;
      case (kind)
         0: load_config(16'd1, 16'd1, 16'd0, 16'd0, 16'd8192, 16'd0);
         1: load_config(16'd15, 16'd81, 16'd48, 16'd655, 16'd40960, 16'd32768);
         2: load_config(16'd0, 16'd127, 16'd63, 16'd1023, 16'd65535, 16'd65535);
         default: begin
            b = ($urandom_range(3) == 0) ? 16'($urandom_range(127)) : 16'($urandom_range(1, 6));
            j = ($urandom_range(3) == 0) ? 16'($urandom_range(63)) : 16'($urandom_range(3));
            n = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(1023));
            load_config(16'($urandom_range(15)), b, j, n,
                        16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end
      endcase
   endtask

   initial begin
      sb = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Register defaults: every sample reloads and passes straight through
      foreach (EDGE_SAMPLES[i])
         send_sample(EDGE_SAMPLES[i]);
      finish_phase();

      // Undecoded indexes, whole-number floor, zero hold, noise, overdrive
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h5A5A);
      load_config(16'd0, 16'd0, 16'd0, 16'd655, 16'd40960, 16'd65535);
      foreach (CRUSH_SAMPLES[i])
         send_sample(CRUSH_SAMPLES[i]);
      finish_phase();

      // Long hold past the counter limit, full noise and gain
      load_config(16'd7, 16'd127, 16'd63, 16'd1023, 16'd65535, 16'd32768);
      for (int i = 0; i < 6; i++)
         send_sample(random_sample());
      finish_phase();

      // Short jittered hold at half level
      load_config(16'd15, 16'd3, 16'd2, 16'd0, 16'd8192, 16'd16384);
      for (int i = 0; i < 6; i++)
         send_sample(random_sample());
      finish_phase();

      // Random-sample phases on extreme, then random settings, rotating through the idle patterns
      for (int p = 0; p < 8; p++) begin
         pick_config(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         if (p == 4)
            long_stall_req = 1'b1;
         for (int i = 0; i < 106; i++)
            send_sample(random_sample());
         finish_phase();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
